@@ rtl/stwa_pkg.sv @@
// ----------------------------------------------------------------------------
// stwa_pkg: shared types and codes for the sighting table
// Entry layout, item codes, result status codes, register indexes and the
// controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package stwa_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ADDR_W = 48;
  localparam int KIND_W = 3;
  localparam int DBM_W  = 8;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [CNT_W-1:0] SIGHT_MAX = '1;

  // register reset values
  localparam logic [15:0] FOLLOW_COUNT_RST = 16'd3;
  localparam logic [31:0] FOLLOW_SPAN_RST  = 32'd300000;
  localparam logic [31:0] STALE_LIMIT_RST  = 32'd120000;

  typedef enum logic [1:0] {
    CFG_FOLLOW_COUNT = 2'd0,
    CFG_FOLLOW_SPAN  = 2'd1,
    CFG_STALE_LIMIT  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    FN_OBSERVE = 2'd0,
    FN_SWEEP   = 2'd1,
    FN_CLEAR   = 2'd2,
    FN_READ    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_UPDATED  = 3'd0,
    STS_INSERTED = 3'd1,
    STS_DROPPED  = 3'd2,
    STS_IGNORED  = 3'd3,
    STS_SWEPT    = 3'd4,
    STS_CLEARED  = 3'd5,
    STS_READ_OK  = 3'd6,
    STS_READ_OOR = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_DATA,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic [KIND_W-1:0]       kind;
    logic signed [DBM_W-1:0] dbm;
    logic [CNT_W-1:0]        sightings;
    logic [TIME_W-1:0]       first_seen;
    logic [TIME_W-1:0]       last_seen;
    logic                    flag;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic [3:0]              slot;
    logic [4:0]              occupancy;
    logic [4:0]              alerts;
    logic [ADDR_W-1:0]       addr;
    logic [KIND_W-1:0]       kind;
    logic signed [DBM_W-1:0] dbm;
    logic [CNT_W-1:0]        sightings;
    logic                    flagged;
    logic [TIME_W-1:0]       span;
  } result_t;

  // Build a result item; entry fields are zero when no entry is touched.
  function automatic result_t make_result(status_t st, logic [3:0] slot,
                                          logic [4:0] occ, logic [4:0] alr,
                                          entry_t e, logic has_entry);
    result_t r;
    r.status    = st;
    r.slot      = slot;
    r.occupancy = occ;
    r.alerts    = alr;
    if (has_entry) begin
      r.addr      = e.addr;
      r.kind      = e.kind;
      r.dbm       = e.dbm;
      r.sightings = e.sightings;
      r.flagged   = e.flag;
      r.span      = e.last_seen - e.first_seen;
    end else begin
      r.addr      = '0;
      r.kind      = '0;
      r.dbm       = '0;
      r.sightings = '0;
      r.flagged   = 1'b0;
      r.span      = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sighting_table_with_aging.sv @@
// ----------------------------------------------------------------------------
// sighting_table_with_aging: device sighting table with follow flags and aging
// Observe, sweep, clear and read items against a table of device entries.
// ----------------------------------------------------------------------------
// One item is worked at a time and gives one result item. The entries live in
// a single memory with one write and one registered read port; observe and
// sweep walk the occupied entries one per cycle through that read port. An
// observe that matches an entry stops its walk at that slot; an observe with
// device kind zero is ignored without a walk. The input is ready again in the
// cycle after the result is loaded. A result waits in the output register
// while the next item is taken in; a result that cannot be loaded because
// the previous one is still held stalls the input. Sweep flags and prunes
// in the same pass, compacting kept entries toward slot 0.
`default_nettype none

module sighting_table_with_aging #(
  parameter int TABLE_DEPTH = stwa_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  // input items
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // device_addr[47:0], device_kind[50:48], signal_dbm[58:51], now_ms[90:59],
  // read_slot[94:91], zero pad[95]
  input  wire logic [95:0]  s_tdata,
  // func[1:0]
  input  wire logic [1:0]   s_tuser,
  // result items
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // slot[3:0], occupancy[8:4], alerts[13:9], out_addr[61:14], out_kind[64:62],
  // out_dbm[72:65], out_sightings[88:73], out_flagged[89],
  // out_span_ms[121:90], zero pad[127:122]
  output logic [127:0]      m_tdata,
  // status[2:0]
  output logic [2:0]        m_tuser
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // input fields
  logic [47:0]       in_addr;
  logic [2:0]        in_kind;
  logic signed [7:0] in_dbm;
  logic [31:0]       in_now;
  logic [3:0]        in_slot;
  logic              s_accept;

  assign in_addr  = s_tdata[47:0];
  assign in_kind  = s_tdata[50:48];
  assign in_dbm   = s_tdata[58:51];
  assign in_now   = s_tdata[90:59];
  assign in_slot  = s_tdata[94:91];
  assign s_accept = s_tvalid && s_tready;

  // registers
  stwa_pkg::state_t   state, state_next;
  stwa_pkg::func_t    op, op_next;
  logic [47:0]        addr_q, addr_q_next;
  logic [2:0]         kind_q, kind_q_next;
  logic signed [7:0]  dbm_q, dbm_q_next;
  logic [31:0]        now_q, now_q_next;
  logic [3:0]         rslot_q, rslot_q_next;
  logic [CNT_W-1:0]   total, total_next;
  logic [CNT_W-1:0]   alert_cnt, alert_cnt_next;
  logic [CNT_W-1:0]   scan_idx, scan_idx_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pidx, pidx_next;
  logic [CNT_W-1:0]   keep, keep_next;
  logic [CNT_W-1:0]   count, count_next;
  stwa_pkg::result_t  res, res_next;
  stwa_pkg::result_t  out_q;
  logic               out_valid;
  logic [15:0]        thr_count;
  logic [31:0]        thr_span;
  logic [31:0]        stale_limit;

  // memory port
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  stwa_pkg::entry_t   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  stwa_pkg::entry_t   ent;

  stwa_table_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(ent)
  );

  // shared decode
  logic        out_free;
  logic        rd_in_range;
  logic        more;
  logic        scan_done;
  logic        match;
  logic [31:0] ent_span;
  logic [31:0] ent_age;
  logic        ent_hit;
  logic        ent_keep;

  assign out_free    = !out_valid || m_tready;
  assign rd_in_range = 32'(in_slot) < 32'(total);
  assign more        = scan_idx < total;
  assign scan_done   = !pend && !more;
  assign match       = pend && (ent.addr == addr_q);
  assign ent_span    = ent.last_seen - ent.first_seen;
  assign ent_age     = now_q - ent.last_seen;
  assign ent_hit     = (ent.sightings >= thr_count) && (ent_span >= thr_span);
  assign ent_keep    = ent_age <= stale_limit;

  assign s_tready  = (state == stwa_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      stwa_pkg::ST_IDLE: begin
        if (s_accept) begin
          case (stwa_pkg::func_t'(s_tuser))
            stwa_pkg::FN_OBSERVE: begin
              state_next = (in_kind == '0) ? stwa_pkg::ST_EMIT : stwa_pkg::ST_SCAN;
            end
            stwa_pkg::FN_SWEEP: state_next = stwa_pkg::ST_SCAN;
            stwa_pkg::FN_CLEAR: state_next = stwa_pkg::ST_EMIT;
            stwa_pkg::FN_READ: begin
              state_next = rd_in_range ? stwa_pkg::ST_RD_DATA : stwa_pkg::ST_EMIT;
            end
            default: state_next = stwa_pkg::ST_EMIT;
          endcase
        end
      end
      stwa_pkg::ST_SCAN: begin
        if ((op == stwa_pkg::FN_OBSERVE && match) || scan_done) begin
          state_next = stwa_pkg::ST_EMIT;
        end
      end
      stwa_pkg::ST_RD_DATA: state_next = stwa_pkg::ST_EMIT;
      stwa_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = stwa_pkg::ST_IDLE;
        end
      end
      default: state_next = stwa_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    stwa_pkg::entry_t e_new;

    op_next        = op;
    addr_q_next    = addr_q;
    kind_q_next    = kind_q;
    dbm_q_next     = dbm_q;
    now_q_next     = now_q;
    rslot_q_next   = rslot_q;
    total_next     = total;
    alert_cnt_next = alert_cnt;
    scan_idx_next  = scan_idx;
    pend_next      = pend;
    pidx_next      = pidx;
    keep_next      = keep;
    count_next     = count;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = pidx;
    mem_wdata      = ent;
    mem_raddr      = scan_idx[IDX_W-1:0];
    e_new          = ent;

    case (state)
      stwa_pkg::ST_IDLE: begin
        mem_raddr = IDX_W'(in_slot);
        if (s_accept) begin
          op_next       = stwa_pkg::func_t'(s_tuser);
          addr_q_next   = in_addr;
          kind_q_next   = in_kind;
          dbm_q_next    = in_dbm;
          now_q_next    = in_now;
          rslot_q_next  = in_slot;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          keep_next     = '0;
          count_next    = '0;
          case (stwa_pkg::func_t'(s_tuser))
            stwa_pkg::FN_OBSERVE: begin
              res_next = stwa_pkg::make_result(stwa_pkg::STS_IGNORED, 4'd0,
                                               5'(total), 5'(alert_cnt), ent, 1'b0);
            end
            stwa_pkg::FN_CLEAR: begin
              total_next     = '0;
              alert_cnt_next = '0;
              res_next = stwa_pkg::make_result(stwa_pkg::STS_CLEARED, 4'd0,
                                               5'd0, 5'd0, ent, 1'b0);
            end
            stwa_pkg::FN_READ: begin
              res_next = stwa_pkg::make_result(stwa_pkg::STS_READ_OOR, in_slot,
                                               5'(total), 5'(alert_cnt), ent, 1'b0);
            end
            default: ;
          endcase
        end
      end

      stwa_pkg::ST_SCAN: begin
        // issue the next read
        if (more) begin
          pend_next     = 1'b1;
          pidx_next     = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + ONE_C;
        end else begin
          pend_next = 1'b0;
        end

        if (op == stwa_pkg::FN_OBSERVE) begin
          if (match) begin
            e_new.dbm       = dbm_q;
            e_new.last_seen = now_q;
            if (ent.sightings != stwa_pkg::SIGHT_MAX) begin
              e_new.sightings = ent.sightings + 16'd1;
            end
            mem_we    = 1'b1;
            mem_waddr = pidx;
            mem_wdata = e_new;
            res_next  = stwa_pkg::make_result(stwa_pkg::STS_UPDATED, 4'(pidx),
                                              5'(total), 5'(alert_cnt), e_new, 1'b1);
          end else if (scan_done) begin
            if (total < DEPTH_C) begin
              e_new.addr       = addr_q;
              e_new.kind       = kind_q;
              e_new.dbm        = dbm_q;
              e_new.sightings  = 16'd1;
              e_new.first_seen = now_q;
              e_new.last_seen  = now_q;
              e_new.flag       = 1'b0;
              mem_we     = 1'b1;
              mem_waddr  = total[IDX_W-1:0];
              mem_wdata  = e_new;
              total_next = total + ONE_C;
              res_next   = stwa_pkg::make_result(stwa_pkg::STS_INSERTED, 4'(total),
                                                 5'(total + ONE_C), 5'(alert_cnt),
                                                 e_new, 1'b1);
            end else begin
              res_next = stwa_pkg::make_result(stwa_pkg::STS_DROPPED, 4'd0,
                                               5'(total), 5'(alert_cnt), ent, 1'b0);
            end
          end
        end else begin
          // sweep: flag, count, and compact kept entries in one pass
          if (pend) begin
            if (ent_hit) begin
              count_next = count + ONE_C;
            end
            if (ent_keep) begin
              e_new.flag = ent.flag | ent_hit;
              mem_we     = 1'b1;
              mem_waddr  = keep[IDX_W-1:0];
              mem_wdata  = e_new;
              keep_next  = keep + ONE_C;
            end
          end else if (scan_done) begin
            total_next     = keep;
            alert_cnt_next = count;
            res_next = stwa_pkg::make_result(stwa_pkg::STS_SWEPT, 4'd0,
                                             5'(keep), 5'(count), ent, 1'b0);
          end
        end
      end

      stwa_pkg::ST_RD_DATA: begin
        res_next = stwa_pkg::make_result(stwa_pkg::STS_READ_OK, rslot_q,
                                         5'(total), 5'(alert_cnt), ent, 1'b1);
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stwa_pkg::ST_IDLE;
      total     <= '0;
      alert_cnt <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      alert_cnt <= alert_cnt_next;
      pend      <= pend_next;
      if (state == stwa_pkg::ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_count   <= stwa_pkg::FOLLOW_COUNT_RST;
      thr_span    <= stwa_pkg::FOLLOW_SPAN_RST;
      stale_limit <= stwa_pkg::STALE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (stwa_pkg::cfg_index_t'(cfg_index))
        stwa_pkg::CFG_FOLLOW_COUNT: thr_count   <= cfg_data[15:0];
        stwa_pkg::CFG_FOLLOW_SPAN:  thr_span    <= cfg_data;
        stwa_pkg::CFG_STALE_LIMIT:  stale_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    addr_q   <= addr_q_next;
    kind_q   <= kind_q_next;
    dbm_q    <= dbm_q_next;
    now_q    <= now_q_next;
    rslot_q  <= rslot_q_next;
    scan_idx <= scan_idx_next;
    pidx     <= pidx_next;
    keep     <= keep_next;
    count    <= count_next;
    res      <= res_next;
    if (state == stwa_pkg::ST_EMIT && out_free) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.status;
  assign m_tdata  = {6'd0, out_q.span, out_q.flagged, out_q.sightings, out_q.dbm,
                     out_q.kind, out_q.addr, out_q.alerts, out_q.occupancy,
                     out_q.slot};

endmodule

`default_nettype wire

@@ rtl/stwa_table_mem.sv @@
// ----------------------------------------------------------------------------
// stwa_table_mem: entry storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stwa_table_mem #(
  parameter int TABLE_DEPTH = stwa_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire stwa_pkg::entry_t   wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output stwa_pkg::entry_t        rdata
);

  stwa_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
